### rtl/core/fsu_pkg.sv
// Shared types and the constant count table for the Fibonacci string unranker.
package fsu_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned LenW  = 6;
  localparam int unsigned RankW = 32;
  localparam int unsigned DigW  = 32;

  // Data carried from one cell to the next.
  typedef struct packed {
    logic [RankW-1:0] rem;
    logic [DigW-1:0]  digits;
    logic             oor;
  } fsu_stage_t;

  // Number of valid words of idx digits: f(0)=1, f(1)=2, f(i)=f(i-1)+f(i-2).
  // Lengths beyond 45 have no count and read as zero.
  function automatic logic [RankW-1:0] fcount(input logic [LenW-1:0] idx);
    logic [RankW-1:0] val;
    case (idx)
      6'd0:  val = 32'd1;
      6'd1:  val = 32'd2;
      6'd2:  val = 32'd3;
      6'd3:  val = 32'd5;
      6'd4:  val = 32'd8;
      6'd5:  val = 32'd13;
      6'd6:  val = 32'd21;
      6'd7:  val = 32'd34;
      6'd8:  val = 32'd55;
      6'd9:  val = 32'd89;
      6'd10: val = 32'd144;
      6'd11: val = 32'd233;
      6'd12: val = 32'd377;
      6'd13: val = 32'd610;
      6'd14: val = 32'd987;
      6'd15: val = 32'd1597;
      6'd16: val = 32'd2584;
      6'd17: val = 32'd4181;
      6'd18: val = 32'd6765;
      6'd19: val = 32'd10946;
      6'd20: val = 32'd17711;
      6'd21: val = 32'd28657;
      6'd22: val = 32'd46368;
      6'd23: val = 32'd75025;
      6'd24: val = 32'd121393;
      6'd25: val = 32'd196418;
      6'd26: val = 32'd317811;
      6'd27: val = 32'd514229;
      6'd28: val = 32'd832040;
      6'd29: val = 32'd1346269;
      6'd30: val = 32'd2178309;
      6'd31: val = 32'd3524578;
      6'd32: val = 32'd5702887;
      6'd33: val = 32'd9227465;
      6'd34: val = 32'd14930352;
      6'd35: val = 32'd24157817;
      6'd36: val = 32'd39088169;
      6'd37: val = 32'd63245986;
      6'd38: val = 32'd102334155;
      6'd39: val = 32'd165580141;
      6'd40: val = 32'd267914296;
      6'd41: val = 32'd433494437;
      6'd42: val = 32'd701408733;
      6'd43: val = 32'd1134903170;
      6'd44: val = 32'd1836311903;
      6'd45: val = 32'd2971215073;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### rtl/core/fsu_entry.sv
// Entry stage: range check of the rank against the word count for the length.
module fsu_entry #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [fsu_pkg::LenW-1:0]      word_length_i,
  input  logic [fsu_pkg::RankW-1:0]     rank_i,
  output logic                          valid_o,
  output fsu_pkg::fsu_stage_t           stage_o
);

  localparam logic [fsu_pkg::LenW-1:0] MaxLen = fsu_pkg::LenW'(MAX_LEN);

  logic                valid_q;
  fsu_pkg::fsu_stage_t stage_q, stage_d;
  logic                bad;

  // A length beyond the chain or a rank past the last word is out of range.
  // An out-of-range item carries a zero remainder, so no cell sets a digit.
  always_comb begin
    bad = (word_length_i > MaxLen) || (rank_i > fsu_pkg::fcount(word_length_i));
    stage_d.oor    = bad;
    stage_d.rem    = bad ? '0 : rank_i;
    stage_d.digits = '0;
  end

  // Valid bit is reset; the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/core/fsu_cell.sv
// One digit cell: decides the digit at position POS and passes the remainder on.
module fsu_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  fsu_pkg::fsu_stage_t stage_i,
  output logic                valid_o,
  output fsu_pkg::fsu_stage_t stage_o
);

  localparam logic [fsu_pkg::RankW-1:0] Count = fsu_pkg::fcount(fsu_pkg::LenW'(POS));

  logic                valid_q;
  fsu_pkg::fsu_stage_t stage_q, stage_d;
  logic                take;

  // Greedy choice: a one here when the remainder exceeds the count below.
  // The remainder then never exceeds the next count, so no two ones touch.
  always_comb begin
    take    = stage_i.rem > Count;
    stage_d = stage_i;
    if (take) begin
      stage_d.rem = stage_i.rem - Count;
    end
  end

  // Positions past the digit field are dropped.
  if (POS < fsu_pkg::DigW) begin : g_digit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q.rem    <= stage_d.rem;
        stage_q.oor    <= stage_d.oor;
        stage_q.digits <= stage_d.digits | (fsu_pkg::DigW'(take) << POS);
      end
    end
  end else begin : g_nodigit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q <= stage_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/core/fibonacci_string_unrank_top.sv
// An accepted item passes through the entry register and then the cell chain to the outputs.
// Throughput: one item per cycle while the result is not stalled; one entry register and one cell per digit position.
// A stalled result freezes the entry stage and the whole cell chain until it is taken.
// Reset clears every valid bit of the chain; payload registers are not reset.
// Top level of the Fibonacci string unranker.
module fibonacci_string_unrank_top #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fsu_pkg::LenW-1:0]      word_length_i,
  input  logic [fsu_pkg::RankW-1:0]     rank_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fsu_pkg::DigW-1:0]      digits_o,
  output logic                          out_of_range_o
);

  logic                advance;
  logic                valid_c [MAX_LEN+1];
  fsu_pkg::fsu_stage_t stage_c [MAX_LEN+1];

  // The chain moves whenever the last cell is empty or its item is taken.
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;

  fsu_entry #(
    .MAX_LEN(MAX_LEN)
  ) u_entry (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .valid_i      (in_valid_i),
    .word_length_i(word_length_i),
    .rank_i       (rank_i),
    .valid_o      (valid_c[0]),
    .stage_o      (stage_c[0])
  );

  // Cell j handles digit position MAX_LEN-1-j, most significant first.
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    fsu_cell #(
      .POS(MAX_LEN - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .valid_i(valid_c[j]),
      .stage_i(stage_c[j]),
      .valid_o(valid_c[j+1]),
      .stage_o(stage_c[j+1])
    );
  end

  // The last cell register is the output register.
  assign out_valid_o    = valid_c[MAX_LEN];
  assign digits_o       = stage_c[MAX_LEN].digits;
  assign out_of_range_o = stage_c[MAX_LEN].oor;

  // An out-of-range result carries no digits.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> digits_o == '0)
    else $error("out-of-range result with nonzero digits");

  // A result never holds two adjacent ones.
  a_no_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digits_o & (digits_o >> 1)) == '0)
    else $error("result holds two adjacent ones");

  // The input side is only held back by a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

endmodule

### test/fibonacci_string_unrank_top_tb.sv
// Self-checking testbench for the Fibonacci string unranker, with a built-in predictor.
module fibonacci_string_unrank_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxLen   = 32;
  localparam int unsigned DrainCyc = MaxLen + 16;

  // One expected word together with the item that caused it.
  typedef struct {
    logic [fsu_pkg::LenW-1:0]  len;
    logic [fsu_pkg::RankW-1:0] rank;
    logic [fsu_pkg::DigW-1:0]  digits;
    logic                      oor;
  } unrank_expect_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [fsu_pkg::LenW-1:0]   word_length_i = '0;
  logic [fsu_pkg::RankW-1:0]  rank_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [fsu_pkg::DigW-1:0]   digits_o;
  logic                       out_of_range_o;

  unrank_expect_t pending_words[$];
  int unsigned    mismatch_count = 0;
  bit             gaps_quiet = 1'b0;
  bit             stall_quiet = 1'b0;

  fibonacci_string_unrank_top #(
    .MAX_LEN(MaxLen)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .word_length_i (word_length_i),
    .rank_i        (rank_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digits_o      (digits_o),
    .out_of_range_o(out_of_range_o)
  );

  always #1 clk_i = ~clk_i;

  // Number of valid words of idx digits with no two adjacent ones.
  function automatic longint unsigned word_count(input int idx);
    longint unsigned a;
    longint unsigned b;
    longint unsigned c;
    a = 64'd1;
    b = 64'd2;
    if (idx == 0) return a;
    for (int i = 2; i <= idx; i++) begin
      c = a + b;
      a = b;
      b = c;
    end
    return b;
  endfunction

  // Greedy Zeckendorf unranking from the top digit down.
  function automatic unrank_expect_t zeckendorf_word(input logic [fsu_pkg::LenW-1:0] len,
                                                     input logic [fsu_pkg::RankW-1:0] rank);
    unrank_expect_t  res;
    longint unsigned rem;
    int              pos;
    res.len    = len;
    res.rank   = rank;
    res.digits = '0;
    res.oor    = 1'b0;
    rem        = 64'(rank);
    if (len > MaxLen || rem > word_count(len)) begin
      res.oor = 1'b1;
      return res;
    end
    pos = int'(len) - 1;
    while (pos >= 0) begin
      if (rem > word_count(pos)) begin
        if (pos < fsu_pkg::DigW) res.digits[pos] = 1'b1;
        rem = rem - word_count(pos);
        pos = pos - 2;
      end else begin
        pos = pos - 1;
      end
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Rank that favors the in-range window and its upper boundary.
  function automatic logic [fsu_pkg::RankW-1:0] choose_rank(
      input logic [fsu_pkg::LenW-1:0] len);
    longint unsigned top;
    if (len > MaxLen) return $urandom;
    top = word_count(len);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1);
      2: return 32'(top - 64'd1 + 64'($urandom_range(0, 3)));
      default: return $urandom_range(0, 32'(top));
    endcase
  endfunction

  // Offer one item, hold it until taken, then record its expected word.
  task automatic send_item(input logic [fsu_pkg::LenW-1:0] len,
                           input logic [fsu_pkg::RankW-1:0] rank);
    int gap;
    in_valid_i    <= 1'b1;
    word_length_i <= len;
    rank_i        <= rank;
    do @(posedge clk_i); while (in_stall_o);
    pending_words.push_back(zeckendorf_word(len, rank));
    gap = gaps_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding word.
  task automatic wait_words_done();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Boundary lengths and ranks, including rank zero and the empty word.
  task automatic test_edge_ranks();
    send_item(6'd0, 32'd0);
    send_item(6'd0, 32'd1);
    send_item(6'd0, 32'd2);
    send_item(6'd1, 32'd0);
    send_item(6'd1, 32'd2);
    send_item(6'd1, 32'd3);
    send_item(6'd2, 32'd3);
    send_item(6'd2, 32'd4);
    send_item(6'd5, 32'd13);
    send_item(6'd5, 32'd14);
    send_item(6'd31, 32'(word_count(31)));
    send_item(6'd32, 32'd0);
    send_item(6'd32, 32'd1);
    send_item(6'd32, 32'd2);
    send_item(6'd32, 32'(word_count(32)));
    send_item(6'd32, 32'(word_count(32) + 1));
    send_item(6'd32, 32'hFFFF_FFFF);
    send_item(6'd33, 32'd1);
    send_item(6'd40, 32'd0);
    send_item(6'd63, 32'd0);
    send_item(6'd63, 32'hFFFF_FFFF);
    wait_words_done();
  endtask

  // Random legal lengths with ranks around the valid window.
  task automatic test_random_ranks(input int count);
    logic [fsu_pkg::LenW-1:0] len;
    for (int i = 0; i < count; i++) begin
      len = (($urandom_range(0, 9) == 0) ? 6'd32 : 6'($urandom_range(0, MaxLen)));
      send_item(len, choose_rank(len));
    end
  endtask

  // Lengths past the supported maximum, mixed with legal ones.
  task automatic test_length_overflow(input int count);
    logic [fsu_pkg::LenW-1:0] len;
    for (int i = 0; i < count; i++) begin
      len = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, MaxLen))
                                        : 6'($urandom_range(MaxLen + 1, 63));
      send_item(len, choose_rank(len));
    end
  endtask

  // Back-to-back items with no stall on either side, then a full drain.
  task automatic test_full_rate(input int count);
    logic [fsu_pkg::LenW-1:0] len;
    wait_words_done();
    gaps_quiet  = 1'b1;
    stall_quiet = 1'b1;
    for (int i = 0; i < count; i++) begin
      len = 6'($urandom_range(0, MaxLen));
      send_item(len, choose_rank(len));
    end
    wait_words_done();
    gaps_quiet  = 1'b0;
    stall_quiet = 1'b0;
  endtask

  // Receiver stalls in bursts of random length.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = pick_gap();
      if (n > 0 && !stall_quiet) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Compare every accepted result with the oldest expected word.
  always @(posedge clk_i) begin
    unrank_expect_t exp_word;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%t: unexpected result, expected none, actual digits %h oor %b",
                 $time, digits_o, out_of_range_o);
        mismatch_count++;
      end else begin
        exp_word = pending_words.pop_front();
        if (digits_o !== exp_word.digits) begin
          $display("%t: digits for len %0d rank %0d: expected %h, actual %h", $time,
                   exp_word.len, exp_word.rank, exp_word.digits, digits_o);
          mismatch_count++;
        end
        if (out_of_range_o !== exp_word.oor) begin
          $display("%t: out_of_range for len %0d rank %0d: expected %b, actual %b", $time,
                   exp_word.len, exp_word.rank, exp_word.oor, out_of_range_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus sequence and the final verdict.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_ranks();
    test_random_ranks(900);
    test_length_overflow(150);
    test_full_rate(300);
    test_random_ranks(150);
    wait_words_done();
    repeat (DrainCyc) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("fibonacci_string_unrank_top_tb: done, clean");
    end else begin
      $display("fibonacci_string_unrank_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4_000_000;
    $display("fibonacci_string_unrank_top_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/core/fsu_pkg.sv
rtl/core/fsu_entry.sv
rtl/core/fsu_cell.sv
rtl/core/fibonacci_string_unrank_top.sv
test/fibonacci_string_unrank_top_tb.sv
